@@ src/bounded_array_list_engine_assert.svh @@
// Assertion macros for the list engine.
// Each check is sampled on clk and held off while rst_n is low.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define BALE_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bale: same-cycle check failed");
// Next-cycle implication.
`define BALE_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bale: next-cycle check failed");
`else
`define BALE_AST_IMP(lbl, ante, cons)
`define BALE_AST_NXT(lbl, ante, cons)
`endif
`endif

@@ src/bale_pkg.sv @@
package bale_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam logic [6:0] CAP_RESET = 7'd64;
  localparam logic signed [31:0] MISS_WORD = -32'sd9999;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_RM_FRONT  = 3'd2,
    CMD_RM_BACK   = 3'd3,
    CMD_FIND      = 3'd4,
    CMD_READ      = 3'd5,
    CMD_WRITE     = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // One finished result word handed from the sequencer to the output stage.
  typedef struct packed {
    status_t            status;
    logic signed [31:0] data;
    logic [5:0]         found_index;
  } res_t;

endpackage

@@ src/bounded_array_list_engine.sv @@
// Bounded array list engine: a packed list of signed 32-bit words held in a
// single-port-write store of MAX_ENTRIES entries, plus a running length.
// Input channel (in_*): one command word per handshake; in_stall is high
// while a command is in progress. Output channel (out_*): exactly one result
// word per command, held in an output register until out_stall is low.
// cfg_we/cfg_wdata write the 7-bit capacity. The user must write it only while
// the block is idle; the block itself does not enforce this.
// Insert back, remove back, write index, refusals and a one-word remove front
// finish straight from idle; read index issues one store read; insert front
// shifts the list up one place, then puts the word at index 0; remove front
// shifts it down one place; find stops at the first hit.
// Front inserts, front removes and finds walk the store one word per cycle
// through its single read port; the sequencer takes no new command until the
// walk and its result are done.
// The sequencer takes the next command as soon as its result moves to the
// output register, so a stalled receiver delays intake by one result only.
// Reset (rst_n low, synchronous) empties the list and sets capacity to 64;
// store contents are not cleared and are never read before being written.
`include "bounded_array_list_engine_assert.svh"

module bounded_array_list_engine #(
  parameter int MAX_ENTRIES = bale_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_value,
  input  logic [5:0]         in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data,
  output logic [5:0]         out_found_index,
  output logic [6:0]         out_count,
  output logic               out_is_full,
  output logic               out_is_empty,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata
);
  import bale_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [CW-1:0] MAX_CW = CW'(MAX_ENTRIES);

  logic [6:0]        cap_r;
  logic [CW-1:0]     cap_lo;
  logic [CW-1:0]     cap_eff;
  logic [CW-1:0]     fill_cw;
  logic              full;

  logic              ctrl_ready;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic [CNT_W-1:0]  fill;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        status_r;
  logic signed [31:0] data_r;
  logic [5:0]        fidx_r;
  logic [6:0]        count_r;
  logic              is_full_r;
  logic              is_empty_r;

  // capacity register, clamped to 1..MAX_ENTRIES on use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign cap_lo  = (cap_r == 7'd0) ? CW'(1) : CW'(cap_r);
  assign cap_eff = (cap_lo > MAX_CW) ? MAX_CW : cap_lo;
  assign fill_cw = CW'(fill);
  assign full    = (fill_cw >= cap_eff);

  bale_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_command  (in_command),
    .in_value    (in_value),
    .in_position (in_position),
    .full_i      (full),
    .ready_o     (ctrl_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .fill_o      (fill)
  );

  assign in_stall = !ctrl_ready;

  // output register: loads when empty or being drained this cycle
  assign res_ready = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_ready) begin
      status_r   <= res.status;
      data_r     <= res.data;
      fidx_r     <= res.found_index;
      count_r    <= 7'(fill);
      is_full_r  <= full;
      is_empty_r <= (fill == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_data        = data_r;
  assign out_found_index = fidx_r;
  assign out_count       = count_r;
  assign out_is_full     = is_full_r;
  assign out_is_empty    = is_empty_r;

  // length never passes the store size
  `BALE_AST_IMP(a_fill_bound, 1'b1, fill_cw <= MAX_CW)
  // every accepted command leaves the sequencer busy in the cycle after it is taken
  `BALE_AST_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // capacity is at least one, so an empty list never reads as full
  `BALE_AST_IMP(a_full_empty_excl, out_valid_r, !(out_is_full && out_is_empty))
  // a handed-off result shows up on the output channel next cycle
  `BALE_AST_NXT(a_result_lands, res_ready, out_valid_r)

endmodule

@@ src/bale_ctrl.sv @@
module bale_ctrl #(
  parameter int MAX_ENTRIES = bale_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic [2:0]                           in_command,
  input  logic signed [31:0]                   in_value,
  input  logic [5:0]                           in_position,
  input  logic                                 full_i,
  output logic                                 ready_o,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output bale_pkg::res_t                       res_o,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]     fill_o
);
  import bale_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CW     = (CNT_W > 6) ? CNT_W : 6;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PUT, S_DONE} state_t;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic signed [31:0]    val_r, val_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [ADDR_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic [ADDR_W-1:0]     pend_addr_r, pend_addr_nxt;
  logic                  pend_r, pend_nxt;
  status_t               status_r, status_nxt;
  logic signed [31:0]    data_r, data_nxt;
  logic [5:0]            fidx_r, fidx_nxt;

  logic signed [31:0]    mem [MAX_ENTRIES];
  logic signed [31:0]    rdata_r;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic signed [31:0]    mem_wdata;

  logic                  empty;
  logic                  pos_big;

  assign empty   = (fill_r == '0);
  assign pos_big = (CW'(in_position) >= CW'(fill_r));

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    fill_nxt      = fill_r;
    rem_nxt       = rem_r;
    rd_idx_nxt    = rd_idx_r;
    pend_addr_nxt = pend_addr_r;
    pend_nxt      = 1'b0;
    status_nxt    = status_r;
    data_nxt      = data_r;
    fidx_nxt      = fidx_r;
    mem_we        = 1'b0;
    mem_waddr     = pend_addr_r;
    mem_wdata     = rdata_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = cmd_t'(in_command);
          val_nxt    = in_value;
          status_nxt = ST_OK;
          data_nxt   = MISS_WORD;
          fidx_nxt   = '0;
          state_nxt  = S_DONE;
          case (cmd_t'(in_command))
            CMD_INS_FRONT: begin
              if (full_i) begin
                status_nxt = ST_FULL;
              end else if (empty) begin
                state_nxt = S_PUT;
              end else begin
                state_nxt  = S_SCAN;
                rd_idx_nxt = ADDR_W'(fill_r - CNT_W'(1));
                rem_nxt    = fill_r;
              end
            end
            CMD_INS_BACK: begin
              if (full_i) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(fill_r);
                mem_wdata = in_value;
                fill_nxt  = fill_r + CNT_W'(1);
              end
            end
            CMD_RM_FRONT: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else if (fill_r == CNT_W'(1)) begin
                fill_nxt = '0;
              end else begin
                state_nxt  = S_SCAN;
                rd_idx_nxt = ADDR_W'(1);
                rem_nxt    = fill_r - CNT_W'(1);
              end
            end
            CMD_RM_BACK: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                fill_nxt = fill_r - CNT_W'(1);
              end
            end
            CMD_FIND: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt  = S_SCAN;
                rd_idx_nxt = '0;
                rem_nxt    = fill_r;
              end
            end
            CMD_READ: begin
              if (pos_big) begin
                status_nxt = ST_MISS;
              end else begin
                state_nxt  = S_SCAN;
                rd_idx_nxt = ADDR_W'(in_position);
                rem_nxt    = CNT_W'(1);
              end
            end
            CMD_WRITE: begin
              if (pos_big) begin
                status_nxt = ST_MISS;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(in_position);
                mem_wdata = in_value;
              end
            end
            default: begin
              status_nxt = ST_MISS;
            end
          endcase
        end
      end
      S_SCAN: begin
        // issue side: one read per cycle
        if (rem_r != '0) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = rd_idx_r;
          rem_nxt       = rem_r - CNT_W'(1);
          if (cmd_r == CMD_INS_FRONT) begin
            rd_idx_nxt = rd_idx_r - ADDR_W'(1);
          end else begin
            rd_idx_nxt = rd_idx_r + ADDR_W'(1);
          end
        end
        // retire side: data read last cycle
        if (pend_r) begin
          case (cmd_r)
            CMD_INS_FRONT: begin
              mem_we    = 1'b1;
              mem_waddr = pend_addr_r + ADDR_W'(1);
              if (rem_r == '0) begin
                state_nxt = S_PUT;
              end
            end
            CMD_RM_FRONT: begin
              mem_we    = 1'b1;
              mem_waddr = pend_addr_r - ADDR_W'(1);
              if (rem_r == '0) begin
                fill_nxt  = fill_r - CNT_W'(1);
                state_nxt = S_DONE;
              end
            end
            CMD_FIND: begin
              if (rdata_r == val_r) begin
                data_nxt  = val_r;
                fidx_nxt  = 6'(pend_addr_r);
                state_nxt = S_DONE;
              end else if (rem_r == '0) begin
                status_nxt = ST_MISS;
                state_nxt  = S_DONE;
              end
            end
            default: begin
              data_nxt  = rdata_r;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = val_r;
        fill_nxt  = fill_r + CNT_W'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      pend_r  <= 1'b0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
      rem_r   <= rem_nxt;
    end
    cmd_r       <= cmd_nxt;
    val_r       <= val_nxt;
    rd_idx_r    <= rd_idx_nxt;
    pend_addr_r <= pend_addr_nxt;
    status_r    <= status_nxt;
    data_r      <= data_nxt;
    fidx_r      <= fidx_nxt;
  end

  // word store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[rd_idx_r];
  end

  assign ready_o            = (state_r == S_IDLE);
  assign res_valid_o        = (state_r == S_DONE);
  assign res_o.status       = status_r;
  assign res_o.data         = data_r;
  assign res_o.found_index  = fidx_r;
  assign fill_o             = fill_r;

endmodule
